>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/m6502x_pkg.sv
// Package with the operation codes, flag positions and result types of the execute unit.
package m6502x_pkg;
  typedef enum logic [5:0] {
    OP_ADC = 6'd0, OP_AND = 6'd1, OP_ASL = 6'd2, OP_BCC = 6'd3, OP_BCS = 6'd4,
    OP_BEQ = 6'd5, OP_BIT = 6'd6, OP_BMI = 6'd7, OP_BNE = 6'd8, OP_BPL = 6'd9,
    OP_BRK = 6'd10, OP_BVC = 6'd11, OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14,
    OP_CLI = 6'd15, OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23, OP_INC = 6'd24,
    OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27, OP_JSR = 6'd28, OP_LDA = 6'd29,
    OP_LDX = 6'd30, OP_LDY = 6'd31, OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34,
    OP_PHA = 6'd35, OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43, OP_SEC = 6'd44,
    OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47, OP_STX = 6'd48, OP_STY = 6'd49,
    OP_TAX = 6'd50, OP_TAY = 6'd51, OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54,
    OP_TYA = 6'd55, OP_NOPP = 6'd56, OP_IRQ = 6'd57, OP_NMI = 6'd58, OP_RST = 6'd59,
    OP_ILL = 6'd60, OP_X61 = 6'd61, OP_X62 = 6'd62, OP_X63 = 6'd63
  } op_t;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_B = 4;
  localparam int FL_U = 5;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  localparam logic [7:0]  SP_RESET    = 8'hFD;
  localparam logic [7:0]  FLAGS_RESET = 8'h20;
  localparam logic [15:0] STACK_BASE  = 16'h0100;
  localparam logic [3:0]  CYC_IRQ     = 4'd7;
  localparam logic [3:0]  CYC_NMI     = 4'd8;

  // Architectural registers.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  // Everything one instruction produces.
  typedef struct packed {
    regs_t       regs;
    logic [15:0] pc;
    logic [3:0]  cyc;
    logic        pen;
    logic [1:0]  nwr;
    logic [15:0] wa0;
    logic [15:0] wa1;
    logic [15:0] wa2;
    logic [7:0]  wd0;
    logic [7:0]  wd1;
    logic [7:0]  wd2;
  } exec_t;

  // Payload of one input item.
  typedef struct packed {
    logic [5:0]  op;
    logic        accumulator_mode;
    logic [7:0]  operand;
    logic [15:0] effective_address;
    logic [15:0] branch_offset;
    logic [15:0] pc_next;
    logic [7:0]  read_first;
    logic [7:0]  read_second;
    logic [7:0]  read_third;
  } in_item_t;

  // Payload of one result item.
  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] pc_out;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [3:0]  cycle_note;
    logic        page_penalty_ok;
    logic        last;
  } out_item_t;
endpackage

>>> rtl/m6502x_if.sv
// Valid/ready channel interfaces for the execute unit.
interface m6502x_in_if;
  import m6502x_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface m6502x_out_if;
  import m6502x_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/m6502x_alu.sv
// Combinational execution of one instruction against the current registers.
module m6502x_alu (
  input  m6502x_pkg::in_item_t itm,
  input  m6502x_pkg::regs_t    cur,
  output m6502x_pkg::exec_t    res
);
  import m6502x_pkg::*;

  logic [8:0]  sum;
  logic [7:0]  addm, src, sh, nz_v, pcn1_lo;
  logic        take, is_br, setnz, irq_go;
  logic [15:0] tgt, pc1, pcm1;
  logic [7:0]  p;
  op_t         op;

  always_comb begin
    op    = op_t'(itm.op);
    res   = '0;
    res.regs = cur;
    res.pc   = itm.pc_next;
    p     = cur.p;
    addm  = (op == OP_SBC) ? ~itm.operand : itm.operand;
    sum   = {1'b0, cur.a} + {1'b0, addm} + {8'd0, cur.p[FL_C]};
    src   = itm.accumulator_mode ? cur.a : itm.operand;
    sh    = '0;
    take  = 1'b0;
    is_br = 1'b0;
    setnz = 1'b0;
    nz_v  = '0;
    pc1   = itm.pc_next + 16'd1;
    pcm1  = itm.pc_next - 16'd1;
    pcn1_lo = '0;
    tgt   = itm.pc_next + itm.branch_offset;
    irq_go = 1'b0;
    case (op)
      OP_ADC, OP_SBC: begin
        res.regs.a = sum[7:0];
        p[FL_C] = sum[8];
        p[FL_V] = ~(cur.a[7] ^ addm[7]) & (cur.a[7] ^ sum[7]);
        nz_v = sum[7:0]; setnz = 1'b1; res.pen = 1'b1;
      end
      OP_AND: begin
        res.regs.a = cur.a & itm.operand; nz_v = res.regs.a; setnz = 1'b1; res.pen = 1'b1;
      end
      OP_EOR: begin
        res.regs.a = cur.a ^ itm.operand; nz_v = res.regs.a; setnz = 1'b1; res.pen = 1'b1;
      end
      OP_ORA: begin
        res.regs.a = cur.a | itm.operand; nz_v = res.regs.a; setnz = 1'b1; res.pen = 1'b1;
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (op)
          OP_ASL: begin sh = {src[6:0], 1'b0}; p[FL_C] = src[7]; end
          OP_LSR: begin sh = {1'b0, src[7:1]}; p[FL_C] = src[0]; end
          OP_ROL: begin sh = {src[6:0], cur.p[FL_C]}; p[FL_C] = src[7]; end
          default: begin sh = {cur.p[FL_C], src[7:1]}; p[FL_C] = src[0]; end
        endcase
        nz_v = sh; setnz = 1'b1;
        if (itm.accumulator_mode) begin
          res.regs.a = sh;
        end else begin
          res.nwr = 2'd1; res.wa0 = itm.effective_address; res.wd0 = sh;
        end
      end
      OP_BCC: begin is_br = 1'b1; take = ~cur.p[FL_C]; end
      OP_BCS: begin is_br = 1'b1; take = cur.p[FL_C]; end
      OP_BEQ: begin is_br = 1'b1; take = cur.p[FL_Z]; end
      OP_BMI: begin is_br = 1'b1; take = cur.p[FL_N]; end
      OP_BNE: begin is_br = 1'b1; take = ~cur.p[FL_Z]; end
      OP_BPL: begin is_br = 1'b1; take = ~cur.p[FL_N]; end
      OP_BVC: begin is_br = 1'b1; take = ~cur.p[FL_V]; end
      OP_BVS: begin is_br = 1'b1; take = cur.p[FL_V]; end
      OP_BIT: begin
        p[FL_Z] = ((cur.a & itm.operand) == 8'd0);
        p[FL_N] = itm.operand[7];
        p[FL_V] = itm.operand[6];
      end
      OP_BRK: begin
        res.nwr = 2'd3;
        res.wa0 = STACK_BASE | {8'd0, cur.sp};          res.wd0 = pc1[15:8];
        res.wa1 = STACK_BASE | {8'd0, cur.sp - 8'd1};   res.wd1 = pc1[7:0];
        res.wa2 = STACK_BASE | {8'd0, cur.sp - 8'd2};
        res.wd2 = cur.p | 8'h30;
        res.regs.sp = cur.sp - 8'd3;
        p[FL_I] = 1'b1;
        res.pc = {itm.read_second, itm.read_first};
      end
      OP_CLC: p[FL_C] = 1'b0;
      OP_CLD: p[FL_D] = 1'b0;
      OP_CLI: p[FL_I] = 1'b0;
      OP_CLV: p[FL_V] = 1'b0;
      OP_SEC: p[FL_C] = 1'b1;
      OP_SED: p[FL_D] = 1'b1;
      OP_SEI: p[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        case (op)
          OP_CMP:  sh = cur.a;
          OP_CPX:  sh = cur.x;
          default: sh = cur.y;
        endcase
        p[FL_C] = (sh >= itm.operand);
        nz_v = sh - itm.operand; setnz = 1'b1; res.pen = 1'b1;
      end
      OP_DEC, OP_INC: begin
        sh = (op == OP_DEC) ? itm.operand - 8'd1 : itm.operand + 8'd1;
        res.nwr = 2'd1; res.wa0 = itm.effective_address; res.wd0 = sh;
        nz_v = sh; setnz = 1'b1;
      end
      OP_DEX: begin res.regs.x = cur.x - 8'd1; nz_v = res.regs.x; setnz = 1'b1; end
      OP_DEY: begin res.regs.y = cur.y - 8'd1; nz_v = res.regs.y; setnz = 1'b1; end
      OP_INX: begin res.regs.x = cur.x + 8'd1; nz_v = res.regs.x; setnz = 1'b1; end
      OP_INY: begin res.regs.y = cur.y + 8'd1; nz_v = res.regs.y; setnz = 1'b1; end
      OP_JMP: res.pc = itm.effective_address;
      OP_JSR: begin
        res.nwr = 2'd2;
        res.wa0 = STACK_BASE | {8'd0, cur.sp};        res.wd0 = pcm1[15:8];
        res.wa1 = STACK_BASE | {8'd0, cur.sp - 8'd1}; res.wd1 = pcm1[7:0];
        res.regs.sp = cur.sp - 8'd2;
        res.pc = itm.effective_address;
      end
      OP_LDA: begin res.regs.a = itm.operand; nz_v = itm.operand; setnz = 1'b1; res.pen = 1'b1; end
      OP_LDX: begin res.regs.x = itm.operand; nz_v = itm.operand; setnz = 1'b1; res.pen = 1'b1; end
      OP_LDY: begin res.regs.y = itm.operand; nz_v = itm.operand; setnz = 1'b1; res.pen = 1'b1; end
      OP_NOPP: res.pen = 1'b1;
      OP_PHA: begin
        res.nwr = 2'd1; res.wa0 = STACK_BASE | {8'd0, cur.sp}; res.wd0 = cur.a;
        res.regs.sp = cur.sp - 8'd1;
      end
      OP_PHP: begin
        res.nwr = 2'd1; res.wa0 = STACK_BASE | {8'd0, cur.sp}; res.wd0 = cur.p | 8'h30;
        res.regs.sp = cur.sp - 8'd1;
      end
      OP_PLA: begin
        res.regs.sp = cur.sp + 8'd1; res.regs.a = itm.read_first;
        nz_v = itm.read_first; setnz = 1'b1;
      end
      OP_PLP: begin
        res.regs.sp = cur.sp + 8'd1;
        p = (itm.read_first & 8'hEF) | 8'h20;
      end
      OP_RTI: begin
        res.regs.sp = cur.sp + 8'd3;
        p = (itm.read_first & 8'hEF) | 8'h20;
        res.pc = {itm.read_third, itm.read_second};
      end
      OP_RTS: begin
        res.regs.sp = cur.sp + 8'd2;
        res.pc = {itm.read_second, itm.read_first} + 16'd1;
      end
      OP_STA: begin res.nwr = 2'd1; res.wa0 = itm.effective_address; res.wd0 = cur.a; end
      OP_STX: begin res.nwr = 2'd1; res.wa0 = itm.effective_address; res.wd0 = cur.x; end
      OP_STY: begin res.nwr = 2'd1; res.wa0 = itm.effective_address; res.wd0 = cur.y; end
      OP_TAX: begin res.regs.x = cur.a; nz_v = cur.a; setnz = 1'b1; end
      OP_TAY: begin res.regs.y = cur.a; nz_v = cur.a; setnz = 1'b1; end
      OP_TSX: begin res.regs.x = cur.sp; nz_v = cur.sp; setnz = 1'b1; end
      OP_TXA: begin res.regs.a = cur.x; nz_v = cur.x; setnz = 1'b1; end
      OP_TXS: res.regs.sp = cur.x;
      OP_TYA: begin res.regs.a = cur.y; nz_v = cur.y; setnz = 1'b1; end
      OP_IRQ, OP_NMI: begin
        irq_go = (op == OP_NMI) || !cur.p[FL_I];
        if (irq_go) begin
          res.nwr = 2'd3;
          res.wa0 = STACK_BASE | {8'd0, cur.sp};        res.wd0 = itm.pc_next[15:8];
          res.wa1 = STACK_BASE | {8'd0, cur.sp - 8'd1}; res.wd1 = itm.pc_next[7:0];
          res.wa2 = STACK_BASE | {8'd0, cur.sp - 8'd2};
          res.wd2 = (cur.p & 8'hEF) | 8'h20;
          res.regs.sp = cur.sp - 8'd3;
          p = p | 8'h24;
          res.pc = {itm.read_second, itm.read_first};
          res.cyc = (op == OP_IRQ) ? CYC_IRQ : CYC_NMI;
        end
      end
      OP_RST: begin
        res.regs = '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: FLAGS_RESET};
        p = FLAGS_RESET;
        res.pc = {itm.read_second, itm.read_first};
        res.cyc = CYC_NMI;
      end
      default: ;
    endcase
    // Branch target and its page-crossing note.
    if (is_br && take) begin
      res.pc  = tgt;
      res.cyc = (tgt[15:8] != itm.pc_next[15:8]) ? 4'd2 : 4'd1;
    end
    if (setnz) begin
      p[FL_Z] = (nz_v == 8'd0);
      p[FL_N] = nz_v[7];
    end
    pcn1_lo = p;
    res.regs.p = pcn1_lo;
  end
endmodule

>>> rtl/mos6502_instruction_execute_unit.sv
// Top level of the 6502 instruction execute unit.
// One instruction item is accepted per cycle while the result side keeps up and the
// held item has at most one write; the registers update at acceptance and the result
// register then delivers one result item per memory write (one to three, or one
// without a write), one per cycle while the receiver is ready. A new instruction is
// accepted only as the last result item of the held one is taken, so an item with
// several writes holds off the input until all its result items have gone.
`include "assert_macros.svh"
module mos6502_instruction_execute_unit (
  input logic               clk,
  input logic               rst_n,
  m6502x_in_if.sink         in_ch,
  m6502x_out_if.source      out_ch
);
  import m6502x_pkg::*;

  regs_t      regs_r;
  exec_t      ex, hold_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic [1:0] cnt;
  logic       last_now, in_acc;
  out_item_t  o;

  m6502x_alu u_alu (.itm(in_ch.data), .cur(regs_r), .res(ex));

  // Number of result items in the held item.
  assign cnt      = (hold_r.nwr == 2'd0) ? 2'd1 : hold_r.nwr;
  assign last_now = (idx_r == cnt - 2'd1);
  assign in_ch.ready = !busy_r || (out_ch.ready && last_now);
  assign in_acc   = in_ch.valid && in_ch.ready;

  // Architectural registers and result sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: FLAGS_RESET};
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (in_acc) begin
        regs_r <= ex.regs;
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r && out_ch.ready) begin
        if (last_now) busy_r <= 1'b0;
        else idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) hold_r <= ex;
  end

  // Result item selection.
  always_comb begin
    o = '0;
    o.write_enable = (hold_r.nwr != 2'd0);
    case (idx_r)
      2'd0: begin o.write_address = hold_r.wa0; o.write_data = hold_r.wd0; end
      2'd1: begin o.write_address = hold_r.wa1; o.write_data = hold_r.wd1; end
      default: begin o.write_address = hold_r.wa2; o.write_data = hold_r.wd2; end
    endcase
    if (!o.write_enable) begin
      o.write_address = '0; o.write_data = '0;
    end
    o.pc_out = hold_r.pc;
    o.acc_out = hold_r.regs.a;
    o.x_out = hold_r.regs.x;
    o.y_out = hold_r.regs.y;
    o.sp_out = hold_r.regs.sp;
    o.status_out = hold_r.regs.p;
    o.cycle_note = hold_r.cyc;
    o.page_penalty_ok = hold_r.pen;
    o.last = last_now;
  end

  assign out_ch.valid = busy_r;
  assign out_ch.data  = o;

  // Checks on the sequencer.
  `ASSERT_IMPL(a_idx_range, busy_r, idx_r < cnt)
  `ASSERT_IMPL(a_u_set, 1'b1, regs_r.p[FL_U])
  `ASSERT_NEXT(a_step, busy_r && out_ch.ready && !last_now && !in_acc, busy_r)
endmodule

>>> verif/tb_mos6502_instruction_execute_unit.sv
// Testbench for the 6502 instruction execute unit: directed and random instructions checked against a predictor.
`timescale 1ns / 1ps
module tb_mos6502_instruction_execute_unit;
  import m6502x_pkg::*;

  logic clk;
  logic rst_n;

  m6502x_in_if  in_ch ();
  m6502x_out_if out_ch ();

  mos6502_instruction_execute_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  localparam int WATCHDOG_LIMIT = 2000;

  // Predicted architectural state.
  logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
  out_item_t  expected_results[$];
  int         error_count;
  bit         idle_enabled;
  int         idle_left;
  int         hold_cycles;
  int         quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void set_zn(logic [7:0] v);
    cpu_p[FL_Z] = (v == 8'h00);
    cpu_p[FL_N] = v[7];
  endfunction

  function automatic void add_to_acc(logic [7:0] m);
    logic [8:0] sum;
    sum = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[FL_C]};
    cpu_p[FL_C] = sum[8];
    cpu_p[FL_V] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ sum[7]);
    cpu_a = sum[7:0];
    set_zn(cpu_a);
  endfunction

  function automatic void compare_with(logic [7:0] r, logic [7:0] m);
    cpu_p[FL_C] = (r >= m);
    set_zn(r - m);
  endfunction

  // Executes one instruction on the predicted state and queues its results.
  function automatic void execute_instruction(in_item_t it);
    logic [15:0] pc, wa[3], tgt;
    logic [7:0]  wd[3], src, res;
    logic [3:0]  cyc;
    logic        pen, take, is_branch;
    int          nw, n;
    out_item_t   r;
    pc = it.pc_next; cyc = 0; pen = 0; nw = 0; take = 0; is_branch = 0;
    case (op_t'(it.op))
      OP_ADC: begin add_to_acc(it.operand); pen = 1; end
      OP_SBC: begin add_to_acc(~it.operand); pen = 1; end
      OP_AND: begin cpu_a &= it.operand; set_zn(cpu_a); pen = 1; end
      OP_EOR: begin cpu_a ^= it.operand; set_zn(cpu_a); pen = 1; end
      OP_ORA: begin cpu_a |= it.operand; set_zn(cpu_a); pen = 1; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        src = it.accumulator_mode ? cpu_a : it.operand;
        case (op_t'(it.op))
          OP_ASL: res = {src[6:0], 1'b0};
          OP_LSR: res = {1'b0, src[7:1]};
          OP_ROL: res = {src[6:0], cpu_p[FL_C]};
          default: res = {cpu_p[FL_C], src[7:1]};
        endcase
        cpu_p[FL_C] = (op_t'(it.op) == OP_ASL || op_t'(it.op) == OP_ROL) ? src[7] : src[0];
        set_zn(res);
        if (it.accumulator_mode) begin
          cpu_a = res;
        end else begin
          wa[nw] = it.effective_address; wd[nw] = res; nw++;
        end
      end
      OP_BCC: begin is_branch = 1; take = !cpu_p[FL_C]; end
      OP_BCS: begin is_branch = 1; take = cpu_p[FL_C]; end
      OP_BEQ: begin is_branch = 1; take = cpu_p[FL_Z]; end
      OP_BMI: begin is_branch = 1; take = cpu_p[FL_N]; end
      OP_BNE: begin is_branch = 1; take = !cpu_p[FL_Z]; end
      OP_BPL: begin is_branch = 1; take = !cpu_p[FL_N]; end
      OP_BVC: begin is_branch = 1; take = !cpu_p[FL_V]; end
      OP_BVS: begin is_branch = 1; take = cpu_p[FL_V]; end
      OP_BIT: begin
        cpu_p[FL_Z] = ((cpu_a & it.operand) == 8'h00);
        cpu_p[FL_N] = it.operand[7];
        cpu_p[FL_V] = it.operand[6];
      end
      OP_BRK: begin
        tgt = it.pc_next + 16'd1;
        wa[0] = STACK_BASE + cpu_sp;         wd[0] = tgt[15:8];
        wa[1] = STACK_BASE + 8'(cpu_sp - 1); wd[1] = tgt[7:0];
        wa[2] = STACK_BASE + 8'(cpu_sp - 2); wd[2] = cpu_p | 8'h30;
        nw = 3; cpu_sp -= 8'd3; cpu_p[FL_I] = 1'b1;
        pc = {it.read_second, it.read_first};
      end
      OP_CLC: cpu_p[FL_C] = 1'b0;
      OP_CLD: cpu_p[FL_D] = 1'b0;
      OP_CLI: cpu_p[FL_I] = 1'b0;
      OP_CLV: cpu_p[FL_V] = 1'b0;
      OP_SEC: cpu_p[FL_C] = 1'b1;
      OP_SED: cpu_p[FL_D] = 1'b1;
      OP_SEI: cpu_p[FL_I] = 1'b1;
      OP_CMP: begin compare_with(cpu_a, it.operand); pen = 1; end
      OP_CPX: begin compare_with(cpu_x, it.operand); pen = 1; end
      OP_CPY: begin compare_with(cpu_y, it.operand); pen = 1; end
      OP_DEC, OP_INC: begin
        res = (op_t'(it.op) == OP_DEC) ? it.operand - 8'd1 : it.operand + 8'd1;
        wa[0] = it.effective_address; wd[0] = res; nw = 1; set_zn(res);
      end
      OP_DEX: begin cpu_x -= 8'd1; set_zn(cpu_x); end
      OP_DEY: begin cpu_y -= 8'd1; set_zn(cpu_y); end
      OP_INX: begin cpu_x += 8'd1; set_zn(cpu_x); end
      OP_INY: begin cpu_y += 8'd1; set_zn(cpu_y); end
      OP_JMP: pc = it.effective_address;
      OP_JSR: begin
        tgt = it.pc_next - 16'd1;
        wa[0] = STACK_BASE + cpu_sp;         wd[0] = tgt[15:8];
        wa[1] = STACK_BASE + 8'(cpu_sp - 1); wd[1] = tgt[7:0];
        nw = 2; cpu_sp -= 8'd2; pc = it.effective_address;
      end
      OP_LDA: begin cpu_a = it.operand; set_zn(cpu_a); pen = 1; end
      OP_LDX: begin cpu_x = it.operand; set_zn(cpu_x); pen = 1; end
      OP_LDY: begin cpu_y = it.operand; set_zn(cpu_y); pen = 1; end
      OP_NOPP: pen = 1;
      OP_PHA: begin
        wa[0] = STACK_BASE + cpu_sp; wd[0] = cpu_a; nw = 1; cpu_sp -= 8'd1;
      end
      OP_PHP: begin
        wa[0] = STACK_BASE + cpu_sp; wd[0] = cpu_p | 8'h30; nw = 1; cpu_sp -= 8'd1;
      end
      OP_PLA: begin cpu_sp += 8'd1; cpu_a = it.read_first; set_zn(cpu_a); end
      OP_PLP: begin cpu_sp += 8'd1; cpu_p = (it.read_first & 8'hEF) | 8'h20; end
      OP_RTI: begin
        cpu_sp += 8'd3; cpu_p = (it.read_first & 8'hEF) | 8'h20;
        pc = {it.read_third, it.read_second};
      end
      OP_RTS: begin
        cpu_sp += 8'd2; pc = {it.read_second, it.read_first} + 16'd1;
      end
      OP_STA: begin wa[0] = it.effective_address; wd[0] = cpu_a; nw = 1; end
      OP_STX: begin wa[0] = it.effective_address; wd[0] = cpu_x; nw = 1; end
      OP_STY: begin wa[0] = it.effective_address; wd[0] = cpu_y; nw = 1; end
      OP_TAX: begin cpu_x = cpu_a; set_zn(cpu_x); end
      OP_TAY: begin cpu_y = cpu_a; set_zn(cpu_y); end
      OP_TSX: begin cpu_x = cpu_sp; set_zn(cpu_x); end
      OP_TXA: begin cpu_a = cpu_x; set_zn(cpu_a); end
      OP_TXS: cpu_sp = cpu_x;
      OP_TYA: begin cpu_a = cpu_y; set_zn(cpu_a); end
      OP_IRQ, OP_NMI: begin
        // A masked interrupt request leaves everything as it is.
        if (!(op_t'(it.op) == OP_IRQ && cpu_p[FL_I])) begin
          wa[0] = STACK_BASE + cpu_sp;         wd[0] = it.pc_next[15:8];
          wa[1] = STACK_BASE + 8'(cpu_sp - 1); wd[1] = it.pc_next[7:0];
          wa[2] = STACK_BASE + 8'(cpu_sp - 2); wd[2] = (cpu_p & 8'hEF) | 8'h20;
          nw = 3; cpu_sp -= 8'd3; cpu_p[FL_I] = 1'b1; cpu_p[FL_U] = 1'b1;
          pc = {it.read_second, it.read_first};
          cyc = (op_t'(it.op) == OP_IRQ) ? CYC_IRQ : CYC_NMI;
        end
      end
      OP_RST: begin
        cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_sp = SP_RESET; cpu_p = FLAGS_RESET;
        pc = {it.read_second, it.read_first}; cyc = CYC_NMI;
      end
      default: ;
    endcase
    if (is_branch && take) begin
      tgt = it.pc_next + it.branch_offset;
      cyc = (tgt[15:8] != it.pc_next[15:8]) ? 4'd2 : 4'd1;
      pc = tgt;
    end
    n = (nw > 0) ? nw : 1;
    for (int k = 0; k < n; k++) begin
      r.write_enable    = (k < nw);
      r.write_address   = (k < nw) ? wa[k] : 16'h0000;
      r.write_data      = (k < nw) ? wd[k] : 8'h00;
      r.pc_out          = pc;
      r.acc_out         = cpu_a;
      r.x_out           = cpu_x;
      r.y_out           = cpu_y;
      r.sp_out          = cpu_sp;
      r.status_out      = cpu_p;
      r.cycle_note      = cyc;
      r.page_penalty_ok = pen;
      r.last            = (k == n - 1);
      expected_results.push_back(r);
    end
  endfunction

  // Sends one instruction item, with an optional random gap before it.
  task automatic send_instruction(in_item_t it);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    execute_instruction(it);
  endtask

  function automatic in_item_t random_instruction(logic [5:0] op);
    in_item_t it;
    it.op                = op;
    it.accumulator_mode  = 1'($urandom);
    it.operand           = 8'($urandom);
    it.effective_address = 16'($urandom);
    it.branch_offset     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                           : {{8{1'($urandom)}}, 8'($urandom)};
    it.pc_next           = 16'($urandom);
    it.read_first        = 8'($urandom);
    it.read_second       = 8'($urandom);
    it.read_third        = 8'($urandom);
    return it;
  endfunction

  task automatic send_op(logic [5:0] op, logic [7:0] operand);
    in_item_t it;
    it = random_instruction(op);
    it.operand = operand;
    send_instruction(it);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Extremes of arithmetic and loads, flags and compares.
  task automatic test_arithmetic();
    send_op(OP_LDA, 8'hFF);
    send_op(OP_ADC, 8'h01);
    send_op(OP_LDA, 8'h7F);
    send_op(OP_ADC, 8'h01);
    send_op(OP_SBC, 8'hFF);
    send_op(OP_CMP, 8'h00);
    send_op(OP_BIT, 8'hC0);
    send_op(OP_ASL, 8'h80);
    send_op(OP_ROR, 8'h01);
    send_op(OP_LDX, 8'h00);
    send_op(OP_DEX, 8'h00);
    send_op(OP_SED, 8'h00);
    send_op(OP_ADC, 8'h99);
  endtask

  // Stack, interrupts and reset, including a masked interrupt request.
  task automatic test_stack_and_interrupts();
    send_op(OP_SEI, 8'h00);
    send_op(OP_IRQ, 8'h00);
    send_op(OP_CLI, 8'h00);
    send_op(OP_IRQ, 8'h00);
    send_op(OP_NMI, 8'h00);
    send_op(OP_BRK, 8'h00);
    send_op(OP_PHP, 8'h00);
    send_op(OP_PLP, 8'hFF);
    send_op(OP_RTI, 8'h00);
    send_op(OP_JSR, 8'h00);
    send_op(OP_RTS, 8'h00);
    send_op(OP_RST, 8'h00);
    send_op(OP_ILL, 8'h00);
    send_op(OP_X63, 8'h00);
    wait_drained();
  endtask

  // Every selector once.
  task automatic test_all_selectors();
    for (int op = 0; op < 64; op++) send_op(6'(op), 8'($urandom));
  endtask

  // Random instructions weighted toward real ones.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_instruction(random_instruction($urandom_range(0, 9) == 0 ?
                       6'($urandom_range(56, 63)) : 6'($urandom_range(0, 55))));
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_cycles = 40;
    for (int i = 0; i < 12; i++) send_op(i % 2 ? OP_BRK : OP_PHA, 8'($urandom));
    wait_drained();
  endtask

  // Result side: random ready with short idle bursts, or a long hold when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      idle_left    <= 0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (idle_left > 0) begin
      out_ch.ready <= 1'b0;
      idle_left    <= idle_left - 1;
    end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      idle_left    <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e, g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (expected_results.size() == 0) begin
        $error("unexpected result item %p", g);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (g.write_enable !== e.write_enable) begin
          $error("write_enable exp %0h got %0h", e.write_enable, g.write_enable);
          error_count++;
        end
        if (g.write_address !== e.write_address) begin
          $error("write_address exp %0h got %0h", e.write_address, g.write_address);
          error_count++;
        end
        if (g.write_data !== e.write_data) begin
          $error("write_data exp %0h got %0h", e.write_data, g.write_data);
          error_count++;
        end
        if (g.pc_out !== e.pc_out) begin
          $error("pc_out exp %0h got %0h", e.pc_out, g.pc_out);
          error_count++;
        end
        if (g.acc_out !== e.acc_out) begin
          $error("acc_out exp %0h got %0h", e.acc_out, g.acc_out);
          error_count++;
        end
        if (g.x_out !== e.x_out) begin
          $error("x_out exp %0h got %0h", e.x_out, g.x_out);
          error_count++;
        end
        if (g.y_out !== e.y_out) begin
          $error("y_out exp %0h got %0h", e.y_out, g.y_out);
          error_count++;
        end
        if (g.sp_out !== e.sp_out) begin
          $error("sp_out exp %0h got %0h", e.sp_out, g.sp_out);
          error_count++;
        end
        if (g.status_out !== e.status_out) begin
          $error("status_out exp %0h got %0h", e.status_out, g.status_out);
          error_count++;
        end
        if (g.cycle_note !== e.cycle_note) begin
          $error("cycle_note exp %0h got %0h", e.cycle_note, g.cycle_note);
          error_count++;
        end
        if (g.page_penalty_ok !== e.page_penalty_ok) begin
          $error("page_penalty_ok exp %0h got %0h", e.page_penalty_ok, g.page_penalty_ok);
          error_count++;
        end
        if (g.last !== e.last) begin
          $error("last exp %0h got %0h", e.last, g.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL mos6502_instruction_execute_unit");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cpu_a = 0; cpu_x = 0; cpu_y = 0; cpu_sp = SP_RESET; cpu_p = FLAGS_RESET;
    error_count = 0; hold_cycles = 0; quiet_cycles = 0; idle_enabled = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_arithmetic();
    test_stack_and_interrupts();
    test_backpressure();
    test_all_selectors();
    test_random(4);
    // Last stretch runs with no idling on either side.
    idle_enabled = 1'b0;
    test_random(8);
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS mos6502_instruction_execute_unit");
    end else begin
      $display("FAIL mos6502_instruction_execute_unit");
    end
    $finish;
  end
endmodule
